### hw/rtl/fla_pkg.sv
// Shared codes and controller/datapath handshake types for the free-list allocator.
package fla_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_IDLE = 3'b010,
    ST_READ = 3'b100
  } state_t;

  typedef struct packed {
    logic init_write;   // clearing pass: write one link entry
    logic accept_now;   // request completes this cycle (free or rejected)
    logic start_alloc;  // successful allocate: link read issued
    logic finish_alloc; // link read data present, complete allocate
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic is_alloc;
    logic alloc_ok;
  } status_t;

endpackage

### hw/rtl/fla_req_if.sv
// Request channel: operation and slot index.
interface fla_req_if #(
  parameter int IDX_W = 10
);
  logic             valid;
  logic             ready;
  logic             operation;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, operation, slot_index, input ready);
  modport sink   (input valid, operation, slot_index, output ready);
endinterface

### hw/rtl/fla_rsp_if.sv
// Result channel: granted slot, success flag, live and peak counts.
interface fla_rsp_if #(
  parameter int IDX_W = 10,
  parameter int CNT_W = 11
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] granted_index;
  logic             success;
  logic [CNT_W-1:0] live_count;
  logic [CNT_W-1:0] peak_count;

  modport source (output valid, granted_index, success, live_count, peak_count,
                  input ready);
  modport sink   (input valid, granted_index, success, live_count, peak_count,
                  output ready);
endinterface

### hw/rtl/fla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/fla_ctrl.sv
// Controller: clearing pass, request sequencing and result valid.
module fla_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  fla_pkg::status_t status,
  output fla_pkg::cmd_t    cmd
);

  fla_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  assign in_ready  = (state_r == fla_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd              = '0;
    cmd.init_write   = (state_r == fla_pkg::ST_INIT);
    cmd.start_alloc  = accept && status.is_alloc && status.alloc_ok;
    cmd.accept_now   = accept && !(status.is_alloc && status.alloc_ok);
    cmd.finish_alloc = (state_r == fla_pkg::ST_READ);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fla_pkg::ST_INIT: begin
        if (status.init_last) begin
          state_nxt = fla_pkg::ST_IDLE;
        end
      end
      fla_pkg::ST_IDLE: begin
        if (cmd.start_alloc) begin
          state_nxt = fla_pkg::ST_READ;
        end
      end
      fla_pkg::ST_READ: state_nxt = fla_pkg::ST_IDLE;
      default:          state_nxt = fla_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.accept_now || cmd.finish_alloc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fla_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/fla_dpath.sv
// Datapath: link memory, head pointer, live/peak counters and result payload.
module fla_dpath #(
  parameter int SLOT_COUNT = 1024,
  parameter int IDX_W      = $clog2(SLOT_COUNT),
  parameter int CNT_W      = $clog2(SLOT_COUNT + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fla_pkg::cmd_t    cmd,
  output fla_pkg::status_t status,
  input  logic             in_operation,
  input  logic [IDX_W-1:0] in_slot_index,
  output logic [IDX_W-1:0] out_granted_index,
  output logic             out_success,
  output logic [CNT_W-1:0] out_live_count,
  output logic [CNT_W-1:0] out_peak_count
);

  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(SLOT_COUNT - 1);

  logic [IDX_W-1:0] init_cnt_r, init_cnt_nxt;
  logic [CNT_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;
  logic [IDX_W-1:0] granted_r, granted_nxt;
  logic             success_r, success_nxt;
  logic [CNT_W-1:0] live_inc;
  logic             free_ok;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [CNT_W-1:0] ram_wdata;
  logic [CNT_W-1:0] ram_rdata;

  assign status.init_last = (init_cnt_r == LAST);
  assign status.is_alloc  = (in_operation == fla_pkg::OP_ALLOC);
  assign status.alloc_ok  = (head_r < SLOTS) && (live_r < SLOTS);
  assign free_ok          = (live_r != '0) && (CNT_W'(in_slot_index) < SLOTS);
  assign live_inc         = live_r + CNT_W'(1);

  assign ram_we    = cmd.init_write || (cmd.accept_now && !status.is_alloc && free_ok);
  assign ram_waddr = cmd.init_write ? init_cnt_r : in_slot_index;
  assign ram_wdata = cmd.init_write ? (CNT_W'(init_cnt_r) + CNT_W'(1)) : head_r;

  fla_ram #(
    .WIDTH (CNT_W),
    .DEPTH (SLOT_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    init_cnt_nxt = init_cnt_r;
    head_nxt     = head_r;
    live_nxt     = live_r;
    peak_nxt     = peak_r;
    granted_nxt  = granted_r;
    success_nxt  = success_r;
    if (cmd.init_write) begin
      init_cnt_nxt = init_cnt_r + IDX_W'(1);
    end
    if (cmd.accept_now) begin
      granted_nxt = '0;
      success_nxt = 1'b0;
      if (!status.is_alloc && free_ok) begin
        head_nxt    = CNT_W'(in_slot_index);
        live_nxt    = live_r - CNT_W'(1);
        success_nxt = 1'b1;
      end
    end
    if (cmd.finish_alloc) begin
      granted_nxt = head_r[IDX_W-1:0];
      success_nxt = 1'b1;
      head_nxt    = ram_rdata;
      live_nxt    = live_inc;
      if (live_inc > peak_r) begin
        peak_nxt = live_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r <= '0;
      head_r     <= '0;
      live_r     <= '0;
      peak_r     <= '0;
    end else begin
      init_cnt_r <= init_cnt_nxt;
      head_r     <= head_nxt;
      live_r     <= live_nxt;
      peak_r     <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    granted_r <= granted_nxt;
    success_r <= success_nxt;
  end

  assign out_granted_index = granted_r;
  assign out_success       = success_r;
  assign out_live_count    = live_r;
  assign out_peak_count    = peak_r;

endmodule

### hw/rtl/free_list_slot_allocator_core.sv
// Free-list slot allocator top level: LIFO pool of SLOT_COUNT slots.
// Latency: a successful allocate waits in ST_READ for the link-memory read data before
// its result is registered; a free or rejected request has it registered on acceptance.
// Throughput: no request is taken in ST_READ, set by the synchronous read of the link
// memory at the head slot; others go at one per cycle unless the result side stalls.
// Reset: a clearing pass writes the link chain, one entry per slot; no request is taken.
module free_list_slot_allocator_core #(
  parameter int SLOT_COUNT = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  fla_req_if.sink         in_req,
  fla_rsp_if.source       out_rsp
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  fla_pkg::cmd_t    cmd;
  fla_pkg::status_t status;

  fla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  fla_dpath #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_operation      (in_req.operation),
    .in_slot_index     (in_req.slot_index),
    .out_granted_index (out_rsp.granted_index),
    .out_success       (out_rsp.success),
    .out_live_count    (out_rsp.live_count),
    .out_peak_count    (out_rsp.peak_count)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for the free-list slot allocator: predicted grants, counts and stalls.
module testbench;

  localparam int SLOT_COUNT = 1024;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [9:0]  granted_index;
    logic        success;
    logic [10:0] live_count;
    logic [10:0] peak_count;
  } alloc_rsp_t;

  logic clk;
  logic rst_n;

  fla_req_if req_ch ();
  fla_rsp_if rsp_ch ();

  free_list_slot_allocator_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  // Shadow of the pool
  logic [10:0] next_free [SLOT_COUNT];
  logic [10:0] free_head;
  logic [10:0] live_slots;
  logic [10:0] peak_slots;
  logic [9:0]  held_slots [$];

  alloc_rsp_t expected_rsps [$];

  int src_idle_pct;
  int snk_idle_pct;
  int fail_count;
  int requests_sent;
  int results_checked;
  int grant_total;
  int refused_allocs;
  int ignored_frees;
  int quiet_cycles;
  logic hold_off;
  event hold_kick;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic string fmt_rsp(input alloc_rsp_t r);
    return $sformatf("granted=%0d ok=%0d live=%0d peak=%0d",
                     r.granted_index, r.success, r.live_count, r.peak_count);
  endfunction

  task automatic predict_request(input logic op, input logic [9:0] slot);
    alloc_rsp_t r;
    int pos [$];
    r = '0;
    if (op == fla_pkg::OP_ALLOC) begin
      if (free_head < SLOT_COUNT && live_slots < SLOT_COUNT) begin
        r.granted_index = free_head[9:0];
        free_head = next_free[free_head[9:0]];
        live_slots = live_slots + 1'b1;
        if (live_slots > peak_slots) peak_slots = live_slots;
        r.success = 1'b1;
        held_slots = {held_slots, r.granted_index};
        grant_total++;
      end else begin
        refused_allocs++;
      end
    end else begin
      if (live_slots != 0 && {1'b0, slot} < SLOT_COUNT) begin
        next_free[slot] = free_head;
        free_head = {1'b0, slot};
        live_slots = live_slots - 1'b1;
        r.success = 1'b1;
        pos = held_slots.find_first_index with (item == slot);
        if (pos.size() != 0) held_slots.delete(pos[0]);
      end else begin
        ignored_frees++;
      end
    end
    r.live_count = live_slots;
    r.peak_count = peak_slots;
    expected_rsps = {expected_rsps, r};
  endtask

  task automatic send_request(input logic op, input logic [9:0] slot);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.slot_index <= slot;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    requests_sent++;
    predict_request(op, slot);
  endtask

  task automatic test_directed();
    send_request(fla_pkg::OP_FREE, 10'd0);      // free with nothing live
    send_request(fla_pkg::OP_FREE, 10'h3ff);
    send_request(fla_pkg::OP_ALLOC, 10'h3ff);   // index ignored on allocate
    send_request(fla_pkg::OP_ALLOC, 10'h000);
    send_request(fla_pkg::OP_ALLOC, 10'h155);
    send_request(fla_pkg::OP_FREE, 10'd1);
    send_request(fla_pkg::OP_ALLOC, 10'h2aa);   // LIFO: slot 1 comes back
    send_request(fla_pkg::OP_FREE, 10'h3ff);    // free of a slot never handed out
    send_request(fla_pkg::OP_ALLOC, 10'd0);
    send_request(fla_pkg::OP_FREE, 10'h3ff);
    send_request(fla_pkg::OP_FREE, 10'd0);
    send_request(fla_pkg::OP_FREE, 10'd2);
    send_request(fla_pkg::OP_FREE, 10'd1);
    send_request(fla_pkg::OP_FREE, 10'd1);      // count back at zero: ignored
    send_request(fla_pkg::OP_ALLOC, 10'd0);
    send_request(fla_pkg::OP_ALLOC, 10'd0);
    send_request(fla_pkg::OP_ALLOC, 10'd0);
    send_request(fla_pkg::OP_ALLOC, 10'd0);
    send_request(fla_pkg::OP_FREE, 10'd1);
    send_request(fla_pkg::OP_FREE, 10'd2);
    send_request(fla_pkg::OP_FREE, 10'd0);
    send_request(fla_pkg::OP_FREE, 10'h3ff);
  endtask

  task automatic test_pool_exhaust();
    while (live_slots < SLOT_COUNT) send_request(fla_pkg::OP_ALLOC, 10'($urandom));
    repeat (3) send_request(fla_pkg::OP_ALLOC, 10'($urandom));
  endtask

  task automatic test_double_free();
    logic [9:0] victim;
    victim = held_slots[$urandom_range(held_slots.size() - 1)];
    send_request(fla_pkg::OP_FREE, victim);
    send_request(fla_pkg::OP_FREE, victim);
    // list now loops on the victim; the live bound must stop the third grant
    repeat (3) send_request(fla_pkg::OP_ALLOC, 10'($urandom));
  endtask

  task automatic test_random_mix(input int n_items, input int alloc_pct);
    int roll;
    repeat (n_items) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        send_request(fla_pkg::OP_FREE, 10'($urandom));
      end else if (roll < 10 + alloc_pct * 90 / 100 || held_slots.size() == 0) begin
        send_request(fla_pkg::OP_ALLOC, 10'($urandom));
      end else begin
        send_request(fla_pkg::OP_FREE, held_slots[$urandom_range(held_slots.size() - 1)]);
      end
    end
  endtask

  task automatic test_backpressure();
    -> hold_kick;
    test_random_mix(40, 50);
  endtask

  // Result side: check, then pick ready for the next edge
  initial begin
    alloc_rsp_t got;
    alloc_rsp_t want;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got = {rsp_ch.granted_index, rsp_ch.success, rsp_ch.live_count, rsp_ch.peak_count};
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %s", $time, fmt_rsp(got));
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          results_checked++;
          if (got !== want) begin
            $display("%0t: mismatch: expected %s, actual %s",
                     $time, fmt_rsp(want), fmt_rsp(got));
            fail_count++;
          end
        end
      end
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    hold_off <= 1'b0;
    forever begin
      @(hold_kick);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog: no request or result moved for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) next_free[i] = 11'(i + 1);
    free_head       = '0;
    live_slots      = '0;
    peak_slots      = '0;
    fail_count      = 0;
    requests_sent   = 0;
    results_checked = 0;
    grant_total     = 0;
    refused_allocs  = 0;
    ignored_frees   = 0;
    src_idle_pct    = 37;
    snk_idle_pct    = 88;
    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= fla_pkg::OP_ALLOC;
    req_ch.slot_index <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_pool_exhaust();
    test_double_free();

    src_idle_pct = 88;
    snk_idle_pct = 37;
    test_random_mix(150, 40);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_backpressure();
    test_random_mix(160, 60);
    req_ch.valid <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d requests, %0d results checked: %0d grants, %0d refused allocates,",
             requests_sent, results_checked, grant_total, refused_allocs);
    $display("%0d ignored frees, full pool, double free and a %0d-cycle result stall; peak %0d",
             ignored_frees, HOLD_CYCLES, peak_slots);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/fla_pkg.sv
hw/rtl/fla_req_if.sv
hw/rtl/fla_rsp_if.sv
hw/rtl/fla_ram.sv
hw/rtl/fla_ctrl.sv
hw/rtl/fla_dpath.sv
hw/rtl/free_list_slot_allocator_core.sv
dv/testbench.sv
